### hdl/assert_macros.svh
// assertion macros shared by the hash engine modules
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error("%m failed");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

### hdl/b2b_pkg.sv
// package for the blake2b hash engine: constants, tables, state type
// no dependencies
package b2b_pkg;
	localparam int unsigned DigestLenDefault = 64;
	localparam int unsigned KeyLenDefault = 0;
	localparam logic [0:0] REG_DIGEST_LEN = 1'b0;
	localparam logic [0:0] REG_KEY_LEN = 1'b1;
	localparam logic [63:0] ALL_ONES = 64'hffff_ffff_ffff_ffff;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_MIX,
		ST_FINISH,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic start;
		logic last;
	} comp_ctl_t;

	function automatic logic [63:0] iv(input logic [2:0] i);
		logic [63:0] r;
		case (i)
			3'd0: r = 64'h6a09e667f3bcc908;
			3'd1: r = 64'hbb67ae8584caa73b;
			3'd2: r = 64'h3c6ef372fe94f82b;
			3'd3: r = 64'ha54ff53a5f1d36f1;
			3'd4: r = 64'h510e527fade682d1;
			3'd5: r = 64'h9b05688c2b3e6c1f;
			3'd6: r = 64'h1f83d9abfb41bd6b;
			default: r = 64'h5be0cd19137e2179;
		endcase
		return r;
	endfunction

	function automatic logic [3:0] sigma(input logic [3:0] row, input logic [3:0] k);
		logic [63:0] s;
		case (row)
			4'd0: s = 64'hfedcba9876543210;
			4'd1: s = 64'h357b20c16df984ae;
			4'd2: s = 64'h491763eadf250c8b;
			4'd3: s = 64'h8f04a562ebcd1397;
			4'd4: s = 64'hd386cb1efa427509;
			4'd5: s = 64'h91ef57d438b0a6c2;
			4'd6: s = 64'hb8293670a4def15c;
			4'd7: s = 64'ha2684f05931ce7bd;
			4'd8: s = 64'h5a417d2c803b9ef6;
			default: s = 64'h0dc3e9bf5167482a;
		endcase
		return s[k*4 +: 4];
	endfunction

	function automatic logic [6:0] clamp_len(input logic [6:0] v, input logic allow_zero);
		logic [6:0] r;
		if (v > 7'd64) r = 7'd64;
		else if (v == 7'd0 && !allow_zero) r = 7'd1;
		else r = v;
		return r;
	endfunction
endpackage

### hdl/b2b_gunit.sv
// shared blake2b g function unit, one half g per cycle
// depends on nothing
module b2b_gunit (
	input  logic [63:0] a,
	input  logic [63:0] b,
	input  logic [63:0] c,
	input  logic [63:0] d,
	input  logic [63:0] m,
	input  logic        phase,
	output logic [63:0] a_o,
	output logic [63:0] b_o,
	output logic [63:0] c_o,
	output logic [63:0] d_o
);
	logic [63:0] a1, t, d1, c1, u;

	// phase 0 rotates by 32 and 24, phase 1 by 16 and 63
	always_comb begin
		a1 = a + b + m;
		t = d ^ a1;
		d1 = phase ? {t[15:0], t[63:16]} : {t[31:0], t[63:32]};
		c1 = c + d1;
		u = b ^ c1;
		a_o = a1;
		d_o = d1;
		c_o = c1;
		b_o = phase ? {u[62:0], u[63]} : {u[23:0], u[63:24]};
	end
endmodule

### hdl/b2b_compress.sv
// blake2b compression sequencer, 192 half-g steps on one shared g unit
// depends on b2b_pkg, b2b_gunit, assert_macros.svh
`include "assert_macros.svh"
module b2b_compress (
	input  logic                clk,
	input  logic                arst_n,
	input  b2b_pkg::comp_ctl_t  ctl,
	input  logic [63:0]         h_in [8],
	input  logic [63:0]         m_in [16],
	input  logic [127:0]        count,
	output logic [63:0]         h_out [8],
	output logic                done
);
	logic [63:0] v_q [16];
	logic [3:0] round_q;
	logic [3:0] step_q;
	logic busy_q;
	logic [3:0] ia, ib, ic, id, row;
	logic [63:0] ao, bo, co, dox;

	always_comb begin
		case (step_q[3:1])
			3'd0: begin ia = 4'd0; ib = 4'd4; ic = 4'd8;  id = 4'd12; end
			3'd1: begin ia = 4'd1; ib = 4'd5; ic = 4'd9;  id = 4'd13; end
			3'd2: begin ia = 4'd2; ib = 4'd6; ic = 4'd10; id = 4'd14; end
			3'd3: begin ia = 4'd3; ib = 4'd7; ic = 4'd11; id = 4'd15; end
			3'd4: begin ia = 4'd0; ib = 4'd5; ic = 4'd10; id = 4'd15; end
			3'd5: begin ia = 4'd1; ib = 4'd6; ic = 4'd11; id = 4'd12; end
			3'd6: begin ia = 4'd2; ib = 4'd7; ic = 4'd8;  id = 4'd13; end
			default: begin ia = 4'd3; ib = 4'd4; ic = 4'd9; id = 4'd14; end
		endcase
		row = (round_q >= 4'd10) ? round_q - 4'd10 : round_q;
	end

	b2b_gunit u_g (
		.a(v_q[ia]), .b(v_q[ib]), .c(v_q[ic]), .d(v_q[id]),
		.m(m_in[b2b_pkg::sigma(row, step_q)]),
		.phase(step_q[0]),
		.a_o(ao), .b_o(bo), .c_o(co), .d_o(dox)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			round_q <= '0;
			step_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				round_q <= '0;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 4'd1;
				if (step_q == 4'd15) begin
					if (round_q == 4'd11) begin
						busy_q <= 1'b0;
						done <= 1'b1;
					end
					round_q <= round_q + 4'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			for (int i = 0; i < 8; i++) v_q[i] <= h_in[i];
			for (int i = 0; i < 4; i++) v_q[i+8] <= b2b_pkg::iv(3'(i));
			v_q[12] <= b2b_pkg::iv(3'd4) ^ count[63:0];
			v_q[13] <= b2b_pkg::iv(3'd5) ^ count[127:64];
			v_q[14] <= b2b_pkg::iv(3'd6) ^ (ctl.last ? b2b_pkg::ALL_ONES : 64'd0);
			v_q[15] <= b2b_pkg::iv(3'd7);
		end else if (busy_q) begin
			v_q[ia] <= ao;
			v_q[ib] <= bo;
			v_q[ic] <= co;
			v_q[id] <= dox;
		end
	end

	always_comb begin
		for (int i = 0; i < 8; i++) h_out[i] = h_in[i] ^ v_q[i] ^ v_q[i+8];
	end

	`ASSERT_NEVER(a_start_busy, clk, arst_n, ctl.start && busy_q)
	`ASSERT_CLK(a_done_pulse, clk, arst_n, done |=> !done)
	`ASSERT_CLK(a_done_end, clk, arst_n, done |-> $past(busy_q) && !busy_q)
endmodule

### hdl/blake2b_hash_engine.sv
// blake2b hash engine (rfc 7693): message gathering, compression control, digest out
// depends on b2b_pkg, b2b_compress, assert_macros.svh
//
// in channel: in_valid/in_stall with message_word, valid_bytes, final_word.
// out channel: out_valid/out_stall with digest_word, digest_index, digest_last.
// cfg channel: cfg_valid/cfg_ready, cfg_index, cfg_data; write only while idle.
// a word into a non-full block is taken without a stall. a word that finds the block
// full first runs a compression and holds in_stall through it: the INIT load,
// 192 half-g steps (12 rounds of 16 on one shared g unit) in MIX, the done
// flag and the FINISH update. a final word runs the last compression (two
// compressions if it also finds the block full), then emits
// ceil(digest length/8) items, one per cycle when out_stall is low; in_stall
// stays high until the last is taken.
// a stalled output item holds. reset restores digest length 64, key length 0
// and opens a fresh message on the next word.
`include "assert_macros.svh"
module blake2b_hash_engine #(
	parameter int unsigned DigestLenReset = b2b_pkg::DigestLenDefault,
	parameter int unsigned KeyLenReset = b2b_pkg::KeyLenDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] message_word,
	input  logic [3:0]  valid_bytes,
	input  logic        final_word,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] digest_word,
	output logic [2:0]  digest_index,
	output logic        digest_last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [6:0]  cfg_data
);
	b2b_pkg::state_t state_q, state_d;
	logic [6:0] dlen_q, klen_q, olen_q;
	logic [63:0] h_q [8];
	logic [63:0] m_q [16];
	logic [127:0] cnt_q;
	logic [7:0] buf_q;
	logic [4:0] slot_q;
	logic open_q, last_q;
	logic [63:0] w_pend_q;
	logic [3:0] n_pend_q;
	logic fin_pend_q;
	logic [2:0] oidx_q;
	b2b_pkg::comp_ctl_t ctl;
	logic [63:0] h_new [8];
	logic done;
	logic acc;
	logic [3:0] n_c;
	logic [63:0] w_c, pw;
	logic [2:0] owords;
	logic [6:0] rem;

	b2b_compress u_comp (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .h_in(h_q), .m_in(m_q),
		.count(cnt_q), .h_out(h_new), .done(done)
	);

	assign cfg_ready = 1'b1;
	assign in_stall = (state_q != b2b_pkg::ST_IDLE);
	assign acc = in_valid && !in_stall;
	assign n_c = (valid_bytes > 4'd8) ? 4'd8 : valid_bytes;
	assign owords = 3'((olen_q - 7'd1) >> 3);
	assign pw = {32'd0, 8'd1, 8'd1, 1'b0, b2b_pkg::clamp_len(klen_q, 1'b1),
		1'b0, b2b_pkg::clamp_len(dlen_q, 1'b0)};

	always_comb begin
		w_c = message_word;
		for (int i = 0; i < 8; i++) if (4'(i) >= n_c) w_c[i*8 +: 8] = 8'd0;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			b2b_pkg::ST_IDLE:
				if (acc && ((n_c != 4'd0 && slot_q[4] && open_q) || final_word))
					state_d = b2b_pkg::ST_INIT;
			b2b_pkg::ST_INIT: state_d = b2b_pkg::ST_MIX;
			b2b_pkg::ST_MIX: if (done) state_d = b2b_pkg::ST_FINISH;
			b2b_pkg::ST_FINISH:
				if (last_q) state_d = b2b_pkg::ST_OUT;
				else if (fin_pend_q) state_d = b2b_pkg::ST_INIT;
				else state_d = b2b_pkg::ST_IDLE;
			b2b_pkg::ST_OUT:
				if (!out_stall && oidx_q == owords) state_d = b2b_pkg::ST_IDLE;
			default: state_d = b2b_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ctl.start = (state_q == b2b_pkg::ST_INIT);
		ctl.last = last_q;
		out_valid = (state_q == b2b_pkg::ST_OUT);
		rem = olen_q - {1'b0, oidx_q, 3'd0};
		digest_word = h_q[oidx_q];
		for (int i = 0; i < 8; i++) if (7'(i) >= rem) digest_word[i*8 +: 8] = 8'd0;
		digest_index = oidx_q;
		digest_last = (oidx_q == owords);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= b2b_pkg::ST_IDLE;
			dlen_q <= 7'(DigestLenReset);
			klen_q <= 7'(KeyLenReset);
			open_q <= 1'b0;
			slot_q <= '0;
			buf_q <= '0;
			oidx_q <= '0;
			last_q <= 1'b0;
			fin_pend_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == b2b_pkg::REG_DIGEST_LEN) dlen_q <= cfg_data;
				else klen_q <= cfg_data;
			end
			if (acc) begin
				open_q <= 1'b1;
				fin_pend_q <= final_word;
				if (!open_q) begin
					slot_q <= (n_c != 4'd0) ? 5'd1 : 5'd0;
					buf_q <= 8'(n_c);
					last_q <= final_word;
				end else if (n_c != 4'd0 && slot_q[4]) begin
					last_q <= 1'b0;
				end else begin
					if (n_c != 4'd0) begin
						slot_q <= slot_q + 5'd1;
						buf_q <= buf_q + 8'(n_c);
					end
					last_q <= final_word;
				end
			end
			if (state_q == b2b_pkg::ST_FINISH) begin
				if (last_q) begin
					oidx_q <= '0;
					open_q <= 1'b0;
				end else begin
					slot_q <= (n_pend_q != 4'd0) ? 5'd1 : 5'd0;
					buf_q <= 8'(n_pend_q);
					if (fin_pend_q) begin
						last_q <= 1'b1;
					end
				end
			end
			if (state_q == b2b_pkg::ST_OUT && !out_stall) oidx_q <= oidx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			w_pend_q <= w_c;
			n_pend_q <= n_c;
			if (!open_q) begin
				olen_q <= b2b_pkg::clamp_len(dlen_q, 1'b0);
				for (int i = 0; i < 8; i++) h_q[i] <= b2b_pkg::iv(3'(i)) ^ ((i == 0) ? pw : 64'd0);
				for (int i = 0; i < 16; i++) m_q[i] <= (i == 0) ? w_c : 64'd0;
				cnt_q <= final_word ? 128'(n_c) : '0;
			end else if (n_c != 4'd0 && slot_q[4]) begin
				cnt_q <= cnt_q + 128'(buf_q);
			end else begin
				if (n_c != 4'd0) m_q[slot_q[3:0]] <= w_c;
				if (final_word) cnt_q <= cnt_q + 128'(buf_q) + 128'(n_c);
			end
		end
		if (state_q == b2b_pkg::ST_FINISH) begin
			for (int i = 0; i < 8; i++) h_q[i] <= h_new[i];
			if (!last_q) begin
				for (int i = 0; i < 16; i++) m_q[i] <= (i == 0) ? w_pend_q : 64'd0;
				if (fin_pend_q) cnt_q <= cnt_q + 128'(n_pend_q);
			end
		end
	end

	`ASSERT_NEVER(a_out_not_idle, clk, arst_n, out_valid && !in_stall)
	`ASSERT_CLK(a_out_hold, clk, arst_n, out_valid && out_stall |=> out_valid && $stable(digest_index))
	`ASSERT_NEVER(a_slot_range, clk, arst_n, slot_q > 5'd16)
endmodule

### dv/tb_blake2b_hash_engine.sv
// testbench for blake2b_hash_engine: feeds messages, directed then random, checks digest items
// depends on b2b_pkg and the rtl of blake2b_hash_engine; prediction by an in-file blake2b model
`timescale 1ns / 100ps
module tb_blake2b_hash_engine;
	localparam int unsigned CYCLE_LIMIT = 600000;
	localparam int unsigned SETTLE = 150;
	localparam bit [63:0] HASH_IV [8] = '{
		64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
		64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};
	localparam bit [3:0] SCHED [10][16] = '{
		'{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15},
		'{14, 10, 4, 8, 9, 15, 13, 6, 1, 12, 0, 2, 11, 7, 5, 3},
		'{11, 8, 12, 0, 5, 2, 15, 13, 10, 14, 3, 6, 7, 1, 9, 4},
		'{7, 9, 3, 1, 13, 12, 11, 14, 2, 6, 5, 10, 4, 0, 15, 8},
		'{9, 0, 5, 7, 2, 4, 10, 15, 14, 1, 11, 12, 6, 8, 3, 13},
		'{2, 12, 6, 10, 0, 11, 8, 3, 4, 13, 7, 5, 15, 14, 1, 9},
		'{12, 5, 1, 15, 14, 13, 4, 10, 0, 7, 6, 3, 9, 2, 8, 11},
		'{13, 11, 7, 14, 12, 1, 3, 9, 5, 0, 15, 4, 8, 6, 2, 10},
		'{6, 15, 14, 9, 11, 3, 0, 8, 12, 2, 13, 7, 1, 4, 10, 5},
		'{10, 2, 8, 4, 7, 6, 1, 5, 15, 11, 9, 14, 3, 12, 13, 0}};

	typedef struct {
		bit [63:0] word;
		bit [2:0]  index;
		bit        last;
	} digest_item_t;

	class digest_scoreboard;
		bit [6:0]     digest_len;
		bit [6:0]     key_len;
		bit [63:0]    chain[8];
		bit [63:0]    block[16];
		bit [63:0]    work[16];
		bit [127:0]   byte_count;
		int unsigned  slots;
		int unsigned  block_bytes;
		bit           msg_open;
		digest_item_t digest_q[$];
		int unsigned  errors;

		function new();
			digest_len = 7'd64;
			key_len = 7'd0;
			msg_open = 0;
			errors = 0;
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		function void write_reg(bit [0:0] idx, bit [6:0] data);
			if (idx == b2b_pkg::REG_DIGEST_LEN) digest_len = data;
			else key_len = data;
		endfunction

		function int unsigned out_len();
			if (digest_len == 0) return 1;
			if (digest_len > 64) return 64;
			return digest_len;
		endfunction

		function void open_message();
			bit [63:0] pw;
			pw = 64'(out_len()) | (64'(key_len > 64 ? 7'd64 : key_len) << 8)
				| (64'd1 << 16) | (64'd1 << 24);
			for (int i = 0; i < 8; i++) chain[i] = HASH_IV[i];
			chain[0] ^= pw;
			for (int i = 0; i < 16; i++) block[i] = '0;
			byte_count = '0;
			slots = 0;
			block_bytes = 0;
		endfunction

		function bit [63:0] ror(bit [63:0] x, int n);
			return (x >> n) | (x << (64 - n));
		endfunction

		function void mix(int a, int b, int c, int d, bit [63:0] x, bit [63:0] y);
			work[a] = work[a] + work[b] + x;
			work[d] = ror(work[d] ^ work[a], 32);
			work[c] = work[c] + work[d];
			work[b] = ror(work[b] ^ work[c], 24);
			work[a] = work[a] + work[b] + y;
			work[d] = ror(work[d] ^ work[a], 16);
			work[c] = work[c] + work[d];
			work[b] = ror(work[b] ^ work[c], 63);
		endfunction

		function void compress(bit last_block);
			int r;
			for (int i = 0; i < 8; i++) begin
				work[i] = chain[i];
				work[i + 8] = HASH_IV[i];
			end
			work[12] ^= byte_count[63:0];
			work[13] ^= byte_count[127:64];
			if (last_block) work[14] ^= b2b_pkg::ALL_ONES;
			for (int k = 0; k < 12; k++) begin
				r = k % 10;
				mix(0, 4, 8, 12, block[SCHED[r][0]], block[SCHED[r][1]]);
				mix(1, 5, 9, 13, block[SCHED[r][2]], block[SCHED[r][3]]);
				mix(2, 6, 10, 14, block[SCHED[r][4]], block[SCHED[r][5]]);
				mix(3, 7, 11, 15, block[SCHED[r][6]], block[SCHED[r][7]]);
				mix(0, 5, 10, 15, block[SCHED[r][8]], block[SCHED[r][9]]);
				mix(1, 6, 11, 12, block[SCHED[r][10]], block[SCHED[r][11]]);
				mix(2, 7, 8, 13, block[SCHED[r][12]], block[SCHED[r][13]]);
				mix(3, 4, 9, 14, block[SCHED[r][14]], block[SCHED[r][15]]);
			end
			for (int i = 0; i < 8; i++) chain[i] ^= work[i] ^ work[i + 8];
		endfunction

		function void note_word(bit [63:0] w, bit [3:0] vb, bit fin);
			int unsigned n;
			int unsigned dl;
			int unsigned words;
			int unsigned rem;
			digest_item_t item;
			n = vb > 8 ? 8 : vb;
			if (n < 8) w &= (64'd1 << (8 * n)) - 64'd1;
			if (!msg_open) begin
				open_message();
				msg_open = 1;
			end
			if (n > 0) begin
				if (slots >= 16) begin
					byte_count += 128'(block_bytes);
					compress(0);
					for (int i = 0; i < 16; i++) block[i] = '0;
					slots = 0;
					block_bytes = 0;
				end
				block[slots] = w;
				slots++;
				block_bytes += n;
			end
			if (!fin) return;
			byte_count += 128'(block_bytes);
			compress(1);
			dl = out_len();
			words = (dl + 7) / 8;
			for (int k = 0; k < words; k++) begin
				item.word = chain[k];
				rem = dl - 8 * k;
				if (rem < 8) item.word &= (64'd1 << (8 * rem)) - 64'd1;
				item.index = 3'(k);
				item.last = (k + 1 == words);
				digest_q.push_back(item);
			end
			msg_open = 0;
		endfunction

		task check_digest(bit [63:0] w, bit [2:0] idx, bit last);
			digest_item_t want;
			if (digest_q.size() == 0) begin
				report($sformatf("unexpected item word %h index %0d", w, idx));
				return;
			end
			want = digest_q.pop_front();
			if (w !== want.word)
				report($sformatf("digest_word %h, want %h", w, want.word));
			if (idx !== want.index)
				report($sformatf("digest_index %0d, want %0d", idx, want.index));
			if (last !== want.last)
				report($sformatf("digest_last %0d, want %0d", last, want.last));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [63:0] message_word;
	logic [3:0]  valid_bytes;
	logic        final_word;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [63:0] digest_word;
	logic [2:0]  digest_index;
	logic        digest_last;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [0:0]  cfg_index;
	logic [6:0]  cfg_data;

	digest_scoreboard sb = new();
	bit          no_idle;
	int unsigned sent;
	int unsigned stall_left = 0;
	int unsigned cycles = 0;

	blake2b_hash_engine i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.message_word(message_word), .valid_bytes(valid_bytes), .final_word(final_word),
		.out_valid(out_valid), .out_stall(out_stall),
		.digest_word(digest_word), .digest_index(digest_index), .digest_last(digest_last),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// receiver: random stall after each item, none while no_idle is set
	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			sb.check_digest(digest_word, digest_index, digest_last);
			stall_left = no_idle ? 0 : $urandom_range(0, 13);
		end
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("*** FAILED ***");
			$finish;
		end
	end

	task send_word(bit [63:0] w, bit [3:0] vb, bit fin);
		int unsigned gap;
		gap = no_idle ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		message_word <= w;
		valid_bytes <= vb;
		final_word <= fin;
		do @(posedge clk); while (in_stall);
		sb.note_word(w, vb, fin);
		if (vb != 0 || fin) sent++;
	endtask

	task drain();
		in_valid <= 1'b0;
		while (sb.digest_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task write_reg(bit [0:0] idx, bit [6:0] data);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, data);
		cfg_valid <= 1'b0;
	endtask

	function bit [63:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	// nfull words (full, or when noisy also empty, short or oversized), then a final word with last_n bytes
	task send_message(int unsigned nfull, bit [3:0] last_n, bit noisy);
		int unsigned r;
		for (int i = 0; i < nfull; i++) begin
			r = noisy ? $urandom_range(0, 19) : 19;
			if (r == 0) send_word(rand_word(), 4'd0, 1'b0);
			else if (r == 1) send_word(rand_word(), 4'($urandom_range(1, 7)), 1'b0);
			else if (r == 2) send_word(rand_word(), 4'($urandom_range(9, 15)), 1'b0);
			else send_word(rand_word(), 4'd8, 1'b0);
		end
		send_word(rand_word(), last_n, 1'b1);
	endtask

	initial begin
		arst_n = 0;
		in_valid = 0;
		message_word = '0;
		valid_bytes = '0;
		final_word = 0;
		cfg_valid = 0;
		cfg_index = '0;
		cfg_data = '0;
		no_idle = 0;
		sent = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed
		send_word(64'd0, 4'd0, 1'b1);
		send_word(b2b_pkg::ALL_ONES, 4'd3, 1'b1);
		send_word(b2b_pkg::ALL_ONES, 4'd15, 1'b1);
		send_message(15, 4'd8, 0);
		send_message(16, 4'd0, 0);
		send_word(b2b_pkg::ALL_ONES, 4'd5, 1'b0);
		send_word(b2b_pkg::ALL_ONES, 4'd0, 1'b0);
		send_word(64'h0123456789abcdef, 4'd8, 1'b0);
		send_word(b2b_pkg::ALL_ONES, 4'd9, 1'b1);
		write_reg(b2b_pkg::REG_DIGEST_LEN, 7'd0);
		write_reg(b2b_pkg::REG_KEY_LEN, 7'd127);
		send_message(2, 4'd1, 0);
		write_reg(b2b_pkg::REG_DIGEST_LEN, 7'd127);
		write_reg(b2b_pkg::REG_KEY_LEN, 7'd32);
		for (int i = 0; i < 16; i++) send_word(i < 4 ? rand_word() : 64'd0, 4'd8, 1'b0);
		send_word(64'd0, 4'd0, 1'b1);
		write_reg(b2b_pkg::REG_DIGEST_LEN, 7'd9);
		write_reg(b2b_pkg::REG_KEY_LEN, 7'd0);
		send_message(3, 4'd7, 0);

		// random
		while (sent < 320) begin
			if ($urandom_range(0, 5) == 0) begin
				write_reg(b2b_pkg::REG_DIGEST_LEN, 7'($urandom_range(0, 127)));
				write_reg(b2b_pkg::REG_KEY_LEN, 7'($urandom_range(0, 4) == 0 ?
					$urandom_range(0, 127) : $urandom_range(0, 64)));
			end
			no_idle = ($urandom_range(0, 4) == 0);
			send_message($urandom_range(0, 4) == 0 ? $urandom_range(0, 40) : $urandom_range(0, 18),
				4'($urandom_range(0, 15)), 1);
		end
		no_idle = 0;
		drain();
		if (sb.errors == 0 && sb.digest_q.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule

### blake2b_hash_engine.f
+incdir+hdl
hdl/b2b_pkg.sv
hdl/b2b_gunit.sv
hdl/b2b_compress.sv
hdl/blake2b_hash_engine.sv
dv/tb_blake2b_hash_engine.sv
